FILE: design/bsa_pkg.sv
package bsa_pkg;

  localparam int CountW = 9;
  localparam int IndexW = 8;
  localparam int ActW   = 2;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;

  typedef enum logic [ActW-1:0] {
    ACT_MARK  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_ALLOC = 2'd2,
    ACT_TEST  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_e;

  typedef struct packed {
    logic [CountW-1:0] free_count;
    logic [IndexW-1:0] alloc_index;
    logic              alloc_ok;
    logic              index_bad;
    logic              was_marked;
  } result_t;

endpackage

FILE: design/bsa_ram.sv
module bsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bitmap_slot_allocator.sv
// An item is accepted only in idle; the map words are read in turn from word 0 up to the word
//   that holds the slot (or the free slot); its result is registered when the output is free.
// The scan speed is set by the single read port of the mark memory, one WORD_BITS word per cycle;
//   a new item is accepted only once the last one's result is registered.
// A finished result waits in the output register while the next item is accepted.
// Reset and every slot count write start a clearing pass of MAP_WORDS words (8 at defaults).
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsa_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bsa_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] slot_index
  input  logic [bsa_pkg::ActW-1:0]      s_axis_tuser,  // [1:0] action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] was_marked, [1] index_bad, [2] alloc_ok, [10:3] alloc_index, [19:11] free_count
  output logic [bsa_pkg::OutDataW-1:0]  m_axis_tdata
);

  import bsa_pkg::*;

  localparam int MapWords  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW     = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int BitW      = $clog2(WORD_BITS);
  localparam int BaseRaw   = $clog2(MAX_SLOTS + WORD_BITS + 1);
  localparam int BaseW     = (BaseRaw > 10) ? BaseRaw : 10;
  localparam int MaxSat    = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
  localparam int ResetLive = (MAX_SLOTS > 256) ? 256 : MAX_SLOTS;
  localparam logic [AddrW-1:0] LastWord = AddrW'(MapWords - 1);

  state_e              state_q, state_d;
  logic [AddrW-1:0]    word_q, word_d;
  logic [BaseW-1:0]    base_q, base_d;
  action_e             act_q;
  logic [IndexW-1:0]   idx_q;
  logic                bad_q;
  logic [CountW-1:0]   live_q, live_d;
  logic [CountW-1:0]   marked_q, marked_d;
  logic                out_valid_q;
  result_t             out_q, res;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rd_data;

  logic                s_accept;
  logic [BaseW-1:0]    rem, offset;
  logic [WORD_BITS-1:0] free_vec;
  logic                any_free, last_word, in_word, cur, done, slot_ok, finish;
  logic [BitW-1:0]     first, sel;

  bsa_ram #(
    .Width (WORD_BITS),
    .Depth (MapWords)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign slot_ok       = !out_valid_q || m_axis_tready;

  always_comb begin
    rem    = BaseW'(live_q) - base_q;
    offset = BaseW'(idx_q) - base_q;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_vec[b] = !rd_data[b] && (BaseW'(b) < rem);
    end
    any_free = |free_vec;
    first    = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        first = BitW'(b);
      end
    end
    last_word = ((base_q + BaseW'(WORD_BITS)) >= BaseW'(live_q)) || (word_q == LastWord);
    in_word   = offset < BaseW'(WORD_BITS);
    sel       = offset[BitW-1:0];
    cur       = rd_data[sel];
    if (bad_q) begin
      done = 1'b1;
    end else if (act_q == ACT_ALLOC) begin
      done = any_free || last_word;
    end else begin
      done = in_word;
    end
  end

  assign finish = (state_q == ST_SCAN) && done && slot_ok;

  always_comb begin
    res       = '0;
    marked_d  = marked_q;
    ram_wdata = rd_data;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    state_d   = state_q;
    word_d    = word_q;
    base_d    = base_q;
    live_d    = live_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        word_d    = word_q + 1'b1;
        if (word_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_re = s_accept;
        word_d = '0;
        base_d = '0;
        if (s_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!done) begin
          ram_re    = 1'b1;
          ram_raddr = word_q + 1'b1;
          word_d    = word_q + 1'b1;
          base_d    = base_q + BaseW'(WORD_BITS);
        end else if (slot_ok) begin
          state_d = ST_IDLE;
          if (bad_q) begin
            res.index_bad = 1'b1;
          end else if (act_q == ACT_ALLOC) begin
            if (any_free) begin
              ram_wdata[first] = 1'b1;
              ram_we           = 1'b1;
              marked_d         = marked_q + 1'b1;
              res.alloc_ok     = 1'b1;
              res.alloc_index  = IndexW'(base_q + BaseW'(first));
            end
          end else begin
            res.was_marked = cur;
            if (act_q == ACT_MARK && !cur) begin
              ram_wdata[sel] = 1'b1;
              ram_we         = 1'b1;
              marked_d       = marked_q + 1'b1;
            end else if (act_q == ACT_CLEAR && cur) begin
              ram_wdata[sel] = 1'b0;
              ram_we         = 1'b1;
              marked_d       = marked_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        word_d  = '0;
      end
    endcase

    res.free_count = live_q - marked_d;

    if (cfg_we_i) begin
      live_d   = (32'(cfg_wdata_i) > MAX_SLOTS) ? CountW'(MaxSat) : cfg_wdata_i;
      marked_d = '0;
      state_d  = ST_CLEAR;
      word_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      word_q      <= '0;
      base_q      <= '0;
      live_q      <= CountW'(ResetLive);
      marked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      word_q   <= word_d;
      base_q   <= base_d;
      live_q   <= live_d;
      marked_q <= marked_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q <= action_e'(s_axis_tuser);
      idx_q <= s_axis_tdata[IndexW-1:0];
      bad_q <= (action_e'(s_axis_tuser) != ACT_ALLOC) &&
               (CountW'(s_axis_tdata[IndexW-1:0]) >= live_q);
    end
    if (finish) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) marked_q <= live_q)
    else $error("marked count exceeds slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (state_q == ST_CLEAR) && (marked_q == '0))
    else $error("slot count write did not start a clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.alloc_ok && (out_q.index_bad || out_q.was_marked)))
    else $error("allocate result carries slot flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.free_count <= live_q))
    else $error("free count above slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || finish)
    else $error("mark memory written outside clear or item completion");

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int SlotLimit   = 256;
  localparam int RandomItems = 1700;
  localparam int DrainCycles = 12;
  localparam int StallLimit  = 5000;
  localparam int ResultW     = $bits(result_t);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ActW-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [SlotLimit-1:0] slot_map;
  int unsigned          live_slots;
  int unsigned          marked_slots;
  result_t              pending_results[$];
  int unsigned          items_sent = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          stall_cycles = 0;
  int unsigned          src_idle_pct = 32;
  int unsigned          snk_idle_pct = 85;

  bitmap_slot_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic void load_slot_count(input logic [CountW-1:0] value);
    live_slots   = (value > SlotLimit) ? SlotLimit : value;
    slot_map     = '0;
    marked_slots = 0;
  endfunction

  function automatic result_t predict_slot_action(input action_e act,
                                                  input logic [IndexW-1:0] idx);
    result_t     res;
    int unsigned i;
    res = '0;
    if (act == ACT_ALLOC) begin
      for (i = 0; i < live_slots && !res.alloc_ok; i++) begin
        if (!slot_map[i]) begin
          slot_map[i]     = 1'b1;
          marked_slots++;
          res.alloc_ok    = 1'b1;
          res.alloc_index = i[IndexW-1:0];
        end
      end
    end else if (idx >= live_slots) begin
      res.index_bad = 1'b1;
    end else begin
      res.was_marked = slot_map[idx];
      if (act == ACT_MARK && !slot_map[idx]) begin
        slot_map[idx] = 1'b1;
        marked_slots++;
      end else if (act == ACT_CLEAR && slot_map[idx]) begin
        slot_map[idx] = 1'b0;
        marked_slots--;
      end
    end
    res.free_count = CountW'(live_slots - marked_slots);
    return res;
  endfunction

  task automatic send_item(input action_e act, input logic [IndexW-1:0] idx);
    if (items_sent < 600) begin
      src_idle_pct = 32;
      snk_idle_pct = 85;
    end else if (items_sent < 1200) begin
      src_idle_pct = 85;
      snk_idle_pct = 32;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_results.push_back(predict_slot_action(act, idx));
    items_sent++;
  endtask

  task automatic write_slot_count(input logic [CountW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_slot_count(value);
  endtask

  task automatic test_default_count();
    send_item(ACT_MARK, 8'd255);
    send_item(ACT_TEST, 8'd255);
    send_item(ACT_MARK, 8'd0);
    send_item(ACT_MARK, 8'd0);
    send_item(ACT_ALLOC, 8'd255);
    send_item(ACT_CLEAR, 8'd0);
    send_item(ACT_CLEAR, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_TEST, 8'hAA);
    send_item(ACT_TEST, 8'h55);
  endtask

  task automatic test_single_slot();
    write_slot_count(9'd1);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_MARK, 8'd1);
    send_item(ACT_TEST, 8'd0);
    send_item(ACT_CLEAR, 8'd0);
  endtask

  task automatic test_zero_slots();
    write_slot_count(9'd0);
    send_item(ACT_MARK, 8'd0);
    send_item(ACT_ALLOC, 8'd0);
    send_item(ACT_TEST, 8'd255);
  endtask

  task automatic test_saturated_count();
    write_slot_count(9'd511);
    send_item(ACT_TEST, 8'd255);
    send_item(ACT_ALLOC, 8'd0);
  endtask

  task automatic test_random_phases();
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       alloc_pct;
    int unsigned       target;
    logic [CountW-1:0] count_val;
    action_e           act;
    logic [IndexW-1:0] idx;
    phase  = 0;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      if (phase == 0) begin
        count_val = 9'd256;
        alloc_pct = 90;
        phase_len = 300;
      end else begin
        case ($urandom_range(9))
          0:       count_val = 9'd256;
          1:       count_val = CountW'($urandom_range(257, 511));
          2:       count_val = 9'd0;
          3, 4, 5, 6: count_val = CountW'($urandom_range(1, 40));
          7, 8:    count_val = CountW'($urandom_range(41, 255));
          default: count_val = CountW'($urandom_range(1, 2));
        endcase
        alloc_pct = $urandom_range(20, 80);
        phase_len = (count_val == 0) ? $urandom_range(5, 15) : $urandom_range(20, 120);
      end
      write_slot_count(count_val);
      repeat (phase_len) begin
        if ($urandom_range(99) < alloc_pct) begin
          act = ACT_ALLOC;
        end else begin
          case ($urandom_range(2))
            0:       act = ACT_MARK;
            1:       act = ACT_CLEAR;
            default: act = ACT_TEST;
          endcase
        end
        if (live_slots > 0 && $urandom_range(99) < 85) begin
          idx = IndexW'($urandom_range(live_slots - 1));
        end else begin
          idx = IndexW'($urandom_range(255));
        end
        send_item(act, idx);
      end
      phase++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got = result_t'(m_axis_tdata[ResultW-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none, got tdata=%h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[OutDataW-1:ResultW] !== '0) begin
          mismatch_count++;
          $display("%0t: mismatch expected was_marked=%0d index_bad=%0d alloc_ok=%0d",
                   $time, want.was_marked, want.index_bad, want.alloc_ok);
          $display("  alloc_index=%0d free_count=%0d pad=0", want.alloc_index,
                   want.free_count);
          $display("  actual was_marked=%0d index_bad=%0d alloc_ok=%0d alloc_index=%0d",
                   got.was_marked, got.index_bad, got.alloc_ok, got.alloc_index);
          $display("  free_count=%0d pad=%0h", got.free_count,
                   m_axis_tdata[OutDataW-1:ResultW]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    load_slot_count(9'd256);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_count();
    test_single_slot();
    test_zero_slots();
    test_saturated_count();
    test_random_phases();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bsa_pkg.sv
design/bsa_ram.sv
design/bitmap_slot_allocator.sv
verif/tb_top.sv
